// File: src/calts_pkg.sv
`timescale 1ns / 1ps
// calts_pkg: types and constants for the calendar time stepper.
// Depends on nothing; used by calendar_time_stepper, calendar_checker and testbench.

package calts_pkg;

    // Field widths of the date and time.
    localparam int MSEC_W   = 10;
    localparam int SEC_W    = 6;
    localparam int MIN_W    = 6;
    localparam int HOUR_W   = 5;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int OUT_YEAR_W = 12;
    localparam int START_YEAR_W = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Residue of the year modulo 400, used for the leap rule.
    localparam int R400_W = 9;
    localparam logic [R400_W-1:0] R400_TOP = 9'd399;
    localparam int LEAP_CYCLE = 400;

    // Highest legal value of each field, one bit wider than the field so
    // that a double increment still compares correctly.
    localparam logic [MSEC_W:0]  MSEC_TOP  = 11'd999;
    localparam logic [SEC_W:0]   SEC_TOP   = 7'd59;
    localparam logic [MIN_W:0]   MIN_TOP   = 7'd59;
    localparam logic [HOUR_W:0]  HOUR_TOP  = 6'd23;
    localparam logic [MONTH_W:0] MONTH_TOP = 5'd12;

    // Unit added per step.
    typedef enum logic [2:0] {
        GRAN_MSEC   = 3'd0,
        GRAN_SECOND = 3'd1,
        GRAN_MINUTE = 3'd2,
        GRAN_HOUR   = 3'd3,
        GRAN_DAY    = 3'd4,
        GRAN_MONTH  = 3'd5,
        GRAN_YEAR   = 3'd6
    } gran_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAN   = 3'd0,
        REG_YEAR   = 3'd1,
        REG_MONTH  = 3'd2,
        REG_DAY    = 3'd3,
        REG_HOUR   = 3'd4,
        REG_MINUTE = 3'd5,
        REG_SECOND = 3'd6,
        REG_MSEC   = 3'd7
    } cfg_idx_t;

    // Leap year from the year's residue modulo 400: divisible by 400, or
    // by 4 but not by 100.
    function automatic logic is_leap(input logic [R400_W-1:0] r);
        logic by4;
        logic century;
        by4     = (r[1:0] == 2'd0);
        century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
        return (r == '0) || (by4 && !century);
    endfunction

    // Days in a month; a month outside 1..12 counts as 31 days.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W:0] mo,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        unique case (mo)
            5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: d = 5'd31;
            5'd4, 5'd6, 5'd9, 5'd11:                    d = 5'd30;
            5'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// File: src/calendar_time_stepper.sv
`timescale 1ns / 1ps
// calendar_time_stepper: Gregorian date and time counter with a config port.
// Depends on calts_pkg.

// Channel  | Ports                                  | Direction | Beat carries
// ---------+----------------------------------------+-----------+---------------------
// input    | s_valid, s_ready, s_advance            | in        | one step request
// result   | m_valid, m_ready, m_out_*              | out       | date and time after
// config   | cfg_valid, cfg_ready, cfg_index, _data | in        | one register write
//
// The full carry chain (msec to year) is a single pass of comparators and
// small adders from the state registers into the result register, so a
// beat is accepted on every clock while the result register is empty or
// being drained. The result appears in the cycle after the beat is taken.
// Synchronous active-low reset loads 0000-01-01 00:00:00.000 and day
// granularity. A stalled result holds in the output register; the input
// stalls only while that register is full and not taken. Config is always
// ready and writes the current time directly.

module calendar_time_stepper #(
    parameter int YEAR_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_advance,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [calts_pkg::OUT_YEAR_W-1:0]       m_out_year,
    output logic [calts_pkg::MONTH_W-1:0]          m_out_month,
    output logic [calts_pkg::DAY_W-1:0]            m_out_day,
    output logic [calts_pkg::HOUR_W-1:0]           m_out_hour,
    output logic [calts_pkg::MIN_W-1:0]            m_out_minute,
    output logic [calts_pkg::SEC_W-1:0]            m_out_second,
    output logic [calts_pkg::MSEC_W-1:0]           m_out_msec,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [calts_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [calts_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import calts_pkg::*;

    // Bits of a written start year that survive the year width.
    localparam int LOAD_BITS = (YEAR_BITS < START_YEAR_W) ? YEAR_BITS : START_YEAR_W;
    // Largest quotient by 400 that a loaded year can reach.
    localparam int MAX_Q = ((2 ** LOAD_BITS) - 1) / LEAP_CYCLE;

    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [R400_W-1:0]    r400;
    } year_t;

    // Year plus one, wrapping at the year width; the residue follows.
    function automatic year_t year_inc(input year_t y);
        year_t n;
        n.year = y.year + 1'b1;
        if (y.year == '1) begin
            n.r400 = '0;
        end else if (y.r400 == R400_TOP) begin
            n.r400 = '0;
        end else begin
            n.r400 = y.r400 + 1'b1;
        end
        return n;
    endfunction

    // Residue modulo 400 of a loaded year: parallel compares against the
    // multiples of 400, then one subtract.
    function automatic logic [R400_W-1:0] load_r400(input logic [LOAD_BITS-1:0] v);
        logic [15:0] base;
        logic [15:0] diff;
        base = '0;
        for (int k = 1; k <= MAX_Q; k++) begin
            if (16'(v) >= 16'(k * LEAP_CYCLE)) begin
                base = 16'(k * LEAP_CYCLE);
            end
        end
        diff = 16'(v) - base;
        return diff[R400_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    gran_t                 gran_reg;
    year_t                 year_reg;
    logic [MONTH_W-1:0]    month_reg;
    logic [DAY_W-1:0]      day_reg;
    logic [HOUR_W-1:0]     hour_reg;
    logic [MIN_W-1:0]      min_reg;
    logic [SEC_W-1:0]      sec_reg;
    logic [MSEC_W-1:0]     msec_reg;

    logic                  m_valid_reg;
    logic [OUT_YEAR_W-1:0] m_year_reg;
    logic [MONTH_W-1:0]    m_month_reg;
    logic [DAY_W-1:0]      m_day_reg;
    logic [HOUR_W-1:0]     m_hour_reg;
    logic [MIN_W-1:0]      m_min_reg;
    logic [SEC_W-1:0]      m_sec_reg;
    logic [MSEC_W-1:0]     m_msec_reg;

    logic                  s_accept;
    logic                  cfg_accept;
    logic [LOAD_BITS-1:0]  year_load;

    // ------------------------------------------------------------------
    // Step: add the unit, then ripple carries upward
    // ------------------------------------------------------------------
    logic add_ms, add_s, add_mi, add_h, add_d, add_mo, add_y;

    logic [MSEC_W:0]  ms1;
    logic [SEC_W:0]   s1;
    logic [MIN_W:0]   mi1;
    logic [HOUR_W:0]  h1;
    logic [DAY_W:0]   d1;
    logic [MONTH_W:0] mo1;
    logic [MONTH_W:0] mo2;
    logic             ms_c, s_c, mi_c, h_c, d_c, mo_c;
    logic [DAY_W-1:0] dim;
    year_t            y1;
    year_t            y2;

    logic [MSEC_W-1:0]  msec_next;
    logic [SEC_W-1:0]   sec_next;
    logic [MIN_W-1:0]   min_next;
    logic [HOUR_W-1:0]  hour_next;
    logic [DAY_W-1:0]   day_next;
    logic [MONTH_W-1:0] month_next;

    always_comb begin
        add_ms = 1'b0;
        add_s  = 1'b0;
        add_mi = 1'b0;
        add_h  = 1'b0;
        add_d  = 1'b0;
        add_mo = 1'b0;
        add_y  = 1'b0;
        unique case (gran_reg)
            GRAN_MSEC:   add_ms = 1'b1;
            GRAN_SECOND: add_s  = 1'b1;
            GRAN_MINUTE: add_mi = 1'b1;
            GRAN_HOUR:   add_h  = 1'b1;
            GRAN_DAY:    add_d  = 1'b1;
            GRAN_MONTH:  add_mo = 1'b1;
            GRAN_YEAR:   add_y  = 1'b1;
            default: ;   // unused code: no unit, carries still normalise
        endcase
    end

    always_comb begin
        // Every field is widened by one bit so out-of-range loads carry.
        ms1  = {1'b0, msec_reg} + (MSEC_W+1)'(add_ms);
        ms_c = (ms1 > MSEC_TOP);
        s1   = {1'b0, sec_reg} + (SEC_W+1)'(add_s) + (SEC_W+1)'(ms_c);
        s_c  = (s1 > SEC_TOP);
        mi1  = {1'b0, min_reg} + (MIN_W+1)'(add_mi) + (MIN_W+1)'(s_c);
        mi_c = (mi1 > MIN_TOP);
        h1   = {1'b0, hour_reg} + (HOUR_W+1)'(add_h) + (HOUR_W+1)'(mi_c);
        h_c  = (h1 > HOUR_TOP);

        // Month and year as they stand before the day check.
        mo1  = {1'b0, month_reg} + (MONTH_W+1)'(add_mo);
        y1   = add_y ? year_inc(year_reg) : year_reg;
        dim  = month_days(mo1, is_leap(y1.r400));

        d1   = {1'b0, day_reg} + (DAY_W+1)'(add_d) + (DAY_W+1)'(h_c);
        d_c  = (d1 > {1'b0, dim});
        mo2  = mo1 + (MONTH_W+1)'(d_c);
        mo_c = (mo2 > MONTH_TOP);
        y2   = mo_c ? year_inc(y1) : y1;

        msec_next  = ms_c ? '0 : ms1[MSEC_W-1:0];
        sec_next   = s_c  ? '0 : s1[SEC_W-1:0];
        min_next   = mi_c ? '0 : mi1[MIN_W-1:0];
        hour_next  = h_c  ? '0 : h1[HOUR_W-1:0];
        day_next   = d_c  ? DAY_W'(1) : d1[DAY_W-1:0];
        month_next = mo_c ? MONTH_W'(1) : mo2[MONTH_W-1:0];
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // Take a new beat whenever the result register is empty or draining.
    assign s_ready    = !m_valid_reg || m_ready;
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign year_load  = cfg_data[LOAD_BITS-1:0];

    // ------------------------------------------------------------------
    // Clock state and configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gran_reg      <= GRAN_DAY;
            year_reg.year <= '0;
            year_reg.r400 <= '0;
            month_reg     <= MONTH_W'(1);
            day_reg       <= DAY_W'(1);
            hour_reg      <= '0;
            min_reg       <= '0;
            sec_reg       <= '0;
            msec_reg      <= '0;
        end else if (cfg_accept) begin
            // Load one field of the current time directly.
            unique case (cfg_idx_t'(cfg_index))
                REG_GRAN:   gran_reg  <= gran_t'(cfg_data[2:0]);
                REG_YEAR: begin
                    year_reg.year <= YEAR_BITS'(year_load);
                    year_reg.r400 <= load_r400(year_load);
                end
                REG_MONTH:  month_reg <= cfg_data[MONTH_W-1:0];
                REG_DAY:    day_reg   <= cfg_data[DAY_W-1:0];
                REG_HOUR:   hour_reg  <= cfg_data[HOUR_W-1:0];
                REG_MINUTE: min_reg   <= cfg_data[MIN_W-1:0];
                REG_SECOND: sec_reg   <= cfg_data[SEC_W-1:0];
                REG_MSEC:   msec_reg  <= cfg_data[MSEC_W-1:0];
            endcase
        end else if (s_accept && s_advance) begin
            // Advance the clock by one unit.
            year_reg  <= y2;
            month_reg <= month_next;
            day_reg   <= day_next;
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            msec_reg  <= msec_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Capture the stepped time, or the current time when advance is clear.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (s_advance) begin
                m_year_reg  <= OUT_YEAR_W'(y2.year);
                m_month_reg <= month_next;
                m_day_reg   <= day_next;
                m_hour_reg  <= hour_next;
                m_min_reg   <= min_next;
                m_sec_reg   <= sec_next;
                m_msec_reg  <= msec_next;
            end else begin
                m_year_reg  <= OUT_YEAR_W'(year_reg.year);
                m_month_reg <= month_reg;
                m_day_reg   <= day_reg;
                m_hour_reg  <= hour_reg;
                m_min_reg   <= min_reg;
                m_sec_reg   <= sec_reg;
                m_msec_reg  <= msec_reg;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_year   = m_year_reg;
    assign m_out_month  = m_month_reg;
    assign m_out_day    = m_day_reg;
    assign m_out_hour   = m_hour_reg;
    assign m_out_minute = m_min_reg;
    assign m_out_second = m_sec_reg;
    assign m_out_msec   = m_msec_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The leap residue tracks the year: 400 is a multiple of 4.
    a_r400_low_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        year_reg.r400[1:0] == year_reg.year[1:0])
        else $error("year residue out of step with year");

    // A beat without advance reports the time as it stood.
    a_hold_on_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_advance |=>
            m_out_msec == $past(msec_reg) && m_out_day == $past(day_reg)
            && m_out_month == $past(month_reg))
        else $error("idle beat changed reported time");

    // The result just captured is the clock's new state.
    a_result_is_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !cfg_accept |=>
            m_out_msec == msec_reg && m_out_hour == hour_reg
            && m_out_year == OUT_YEAR_W'(year_reg.year))
        else $error("result differs from clock state");

endmodule

// File: verif/calendar_checker.sv
`timescale 1ns / 1ps
// calendar_checker: predicts the date and time after every step beat of the
// calendar time stepper and compares each result beat, in order, field by field.
// Depends on calts_pkg for widths, granularity codes and register indexes.

module calendar_checker #(
    parameter int YEAR_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_advance,

    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [calts_pkg::OUT_YEAR_W-1:0] m_out_year,
    input  logic [calts_pkg::MONTH_W-1:0]    m_out_month,
    input  logic [calts_pkg::DAY_W-1:0]      m_out_day,
    input  logic [calts_pkg::HOUR_W-1:0]     m_out_hour,
    input  logic [calts_pkg::MIN_W-1:0]      m_out_minute,
    input  logic [calts_pkg::SEC_W-1:0]      m_out_second,
    input  logic [calts_pkg::MSEC_W-1:0]     m_out_msec,

    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [calts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [calts_pkg::CFG_DATA_W-1:0] cfg_data,

    output int                               stamps_pending,
    output int                               mismatch_count
);

    import calts_pkg::*;

    localparam int unsigned YEAR_MASK = (32'd1 << YEAR_BITS) - 32'd1;

    typedef struct {
        logic [YEAR_BITS-1:0] year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [HOUR_W-1:0]    hour;
        logic [MIN_W-1:0]     minute;
        logic [SEC_W-1:0]     second;
        logic [MSEC_W-1:0]    msec;
    } stamp_t;

    stamp_t      clock_now;
    logic [2:0]  step_unit;
    stamp_t      expected_stamps[$];

    function automatic bit leap_rule(int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    // Months outside 1..12 count as 31 days long.
    function automatic int unsigned month_span(int unsigned mo, int unsigned y);
        case (mo)
            4, 6, 9, 11: return 30;
            2:           return leap_rule(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Add one unit, then ripple carries upward at full precision so that
    // out-of-range loaded fields overflow like normal ones.
    function automatic stamp_t tick_calendar(stamp_t now, logic [2:0] unit);
        stamp_t      nxt;
        int unsigned ms, s, mi, h, d, mo, y;
        ms = now.msec;
        s  = now.second;
        mi = now.minute;
        h  = now.hour;
        d  = now.day;
        mo = now.month;
        y  = now.year;
        case (unit)
            GRAN_MSEC:   ms++;
            GRAN_SECOND: s++;
            GRAN_MINUTE: mi++;
            GRAN_HOUR:   h++;
            GRAN_DAY:    d++;
            GRAN_MONTH:  mo++;
            GRAN_YEAR:   y = (y + 1) & YEAR_MASK;
            default:     ;
        endcase
        if (ms > 999) begin ms = 0; s++;  end
        if (s > 59)   begin s = 0;  mi++; end
        if (mi > 59)  begin mi = 0; h++;  end
        if (h > 23)   begin h = 0;  d++;  end
        if (d > month_span(mo, y)) begin d = 1; mo++; end
        if (mo > 12)  begin mo = 1; y = (y + 1) & YEAR_MASK; end
        nxt.msec   = MSEC_W'(ms);
        nxt.second = SEC_W'(s);
        nxt.minute = MIN_W'(mi);
        nxt.hour   = HOUR_W'(h);
        nxt.day    = DAY_W'(d);
        nxt.month  = MONTH_W'(mo);
        nxt.year   = YEAR_BITS'(y & YEAR_MASK);
        return nxt;
    endfunction

    task automatic log_error(string msg);
        $display("[%0t] calendar check: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            log_error($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    always @(posedge aclk) begin
        stamp_t want;
        if (!aresetn) begin
            clock_now = '{year: '0, month: 1, day: 1, hour: 0, minute: 0, second: 0, msec: 0};
            step_unit = GRAN_DAY;
            expected_stamps.delete();
        end else begin
            // Results first: a beat accepted now belongs to an older step.
            if (m_valid && m_ready) begin
                if (expected_stamps.size() == 0) begin
                    log_error("result beat with no step outstanding");
                end else begin
                    want = expected_stamps.pop_front();
                    check_field("year",   m_out_year,   OUT_YEAR_W'(want.year));
                    check_field("month",  m_out_month,  want.month);
                    check_field("day",    m_out_day,    want.day);
                    check_field("hour",   m_out_hour,   want.hour);
                    check_field("minute", m_out_minute, want.minute);
                    check_field("second", m_out_second, want.second);
                    check_field("msec",   m_out_msec,   want.msec);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GRAN:   step_unit        = cfg_data[2:0];
                    REG_YEAR:   clock_now.year   = YEAR_BITS'(cfg_data & YEAR_MASK);
                    REG_MONTH:  clock_now.month  = cfg_data[MONTH_W-1:0];
                    REG_DAY:    clock_now.day    = cfg_data[DAY_W-1:0];
                    REG_HOUR:   clock_now.hour   = cfg_data[HOUR_W-1:0];
                    REG_MINUTE: clock_now.minute = cfg_data[MIN_W-1:0];
                    REG_SECOND: clock_now.second = cfg_data[SEC_W-1:0];
                    REG_MSEC:   clock_now.msec   = cfg_data[MSEC_W-1:0];
                    default:    ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_advance)
                    clock_now = tick_calendar(clock_now, step_unit);
                expected_stamps.push_back(clock_now);
            end
        end
        stamps_pending <= expected_stamps.size();
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: stimulus, clock, reset and verdict for calendar_time_stepper.
// Depends on calts_pkg, calendar_time_stepper and calendar_checker.

module testbench;
    import calts_pkg::*;

    localparam int YEAR_BITS      = 12;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    // Granularity code with no unit attached: only the carry chain runs.
    localparam logic [2:0] GRAN_UNUSED = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn;

    logic                  s_valid;
    logic                  s_ready;
    logic                  s_advance;

    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_YEAR_W-1:0] m_out_year;
    logic [MONTH_W-1:0]    m_out_month;
    logic [DAY_W-1:0]      m_out_day;
    logic [HOUR_W-1:0]     m_out_hour;
    logic [MIN_W-1:0]      m_out_minute;
    logic [SEC_W-1:0]      m_out_second;
    logic [MSEC_W-1:0]     m_out_msec;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    stamps_pending;
    int                    mismatch_count;

    // Long receiver hold: the stimulus raises a request, the sink serves it.
    int                    hold_requests = 0;
    int                    holds_served  = 0;
    int                    quiet_cycles  = 0;

    always #HALF_PERIOD aclk = ~aclk;

    calendar_time_stepper #(
        .YEAR_BITS (YEAR_BITS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_advance    (s_advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_year   (m_out_year),
        .m_out_month  (m_out_month),
        .m_out_day    (m_out_day),
        .m_out_hour   (m_out_hour),
        .m_out_minute (m_out_minute),
        .m_out_second (m_out_second),
        .m_out_msec   (m_out_msec),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    calendar_checker #(
        .YEAR_BITS (YEAR_BITS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_advance      (s_advance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_year     (m_out_year),
        .m_out_month    (m_out_month),
        .m_out_day      (m_out_day),
        .m_out_hour     (m_out_hour),
        .m_out_minute   (m_out_minute),
        .m_out_second   (m_out_second),
        .m_out_msec     (m_out_msec),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .stamps_pending (stamps_pending),
        .mismatch_count (mismatch_count)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Start value for one field: often just below its rollover, sometimes
    // anywhere legal or at its floor, and now and then any raw bit pattern
    // so that out-of-range loads get exercised too.
    function automatic int unsigned pick_field(int unsigned lo, int unsigned top,
                                               int unsigned width);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return $urandom_range(top - 2, top);
        if (roll < 85) return $urandom_range(lo, top);
        if (roll < 93) return lo;
        return $urandom_range(0, (32'd1 << width) - 1);
    endfunction

    // One register write beat. Hold cfg_valid high on return so that
    // back-to-back writes never drop it between beats; the caller lowers it.
    task automatic write_field(cfg_idx_t idx, int unsigned value, int unsigned width,
                               bit noisy);
        int unsigned data;
        data = value & ((32'd1 << width) - 1);
        // Set bits above the register width: the block must drop them.
        if (noisy && $urandom_range(0, 99) < 15)
            data = data | ($urandom() << width);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Write the granularity and every start register, loading the clock.
    task automatic load_time(logic [2:0] unit, int unsigned y, int unsigned mo,
                             int unsigned d, int unsigned h, int unsigned mi,
                             int unsigned s, int unsigned ms, bit noisy);
        write_field(REG_GRAN,   unit, $bits(gran_t), noisy);
        write_field(REG_YEAR,   y,    START_YEAR_W,  noisy);
        write_field(REG_MONTH,  mo,   MONTH_W,       noisy);
        write_field(REG_DAY,    d,    DAY_W,         noisy);
        write_field(REG_HOUR,   h,    HOUR_W,        noisy);
        write_field(REG_MINUTE, mi,   MIN_W,         noisy);
        write_field(REG_SECOND, s,    SEC_W,         noisy);
        write_field(REG_MSEC,   ms,   MSEC_W,        noisy);
        cfg_valid <= 1'b0;
    endtask

    // One step beat. In a burst keep s_valid high straight into the next
    // beat; otherwise drop it for a random gap.
    task automatic send_step(logic adv, bit burst);
        int gap;
        gap = burst ? 0 : idle_len();
        s_advance <= adv;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering steps and wait until every expected result has arrived,
    // so the block is idle before the next register write.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (stamps_pending != 0);
    endtask

    // Result sink: random stalls, calm stretches with ready held high, and
    // the long hold when the stimulus asks for one.
    initial begin : result_sink
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                // Hold off long enough for the output register to fill and
                // the input to stall behind it.
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                holds_served <= holds_served + 1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) < 3)
                    calm_left = $urandom_range(20, 60);
                else if ($urandom_range(0, 99) < 35)
                    stall_left = idle_len();
            end
        end
    end

    // Watchdog: any accepted beat on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int          random_sent;
        int          phase;
        int          n;
        int          roll;
        bit          burst;
        logic [2:0]  unit;
        int unsigned start_year;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_advance <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_GRAN;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- Directed part ------------------------------------------------

        // Reset state, day granularity; a beat without advance reports the
        // current time unchanged.
        send_step(1'b1, 1'b0);
        send_step(1'b0, 1'b0);
        send_step(1'b1, 1'b0);

        // Full ripple from the last millisecond of a century into a year
        // divisible by 400.
        drain();
        load_time(GRAN_MSEC, 1999, 12, 31, 23, 59, 59, 999, 1'b0);
        send_step(1'b1, 1'b0);
        send_step(1'b1, 1'b0);

        // Every field loaded at its all-ones value: each one overflows and
        // the year wraps to zero.
        drain();
        load_time(GRAN_MSEC, 4095, 15, 31, 31, 63, 63, 1023, 1'b0);
        send_step(1'b1, 1'b0);

        // Second, minute and hour units rolling over midnight on 28 February in a
        // common year, a leap year and a century that is not leap.
        drain();
        load_time(GRAN_SECOND, 2023, 2, 28, 23, 59, 59, 500, 1'b0);
        send_step(1'b1, 1'b0);
        drain();
        load_time(GRAN_MINUTE, 2024, 2, 28, 23, 59, 10, 0, 1'b0);
        send_step(1'b1, 1'b0);
        drain();
        load_time(GRAN_HOUR, 1900, 2, 28, 23, 30, 0, 0, 1'b0);
        send_step(1'b1, 1'b0);

        // Day unit through 29 February of a year divisible by 400.
        drain();
        load_time(GRAN_DAY, 2000, 2, 28, 12, 0, 0, 0, 1'b0);
        send_step(1'b1, 1'b0);
        send_step(1'b1, 1'b0);

        // Month unit: 31 January rolls past February into March, then the
        // year end.
        drain();
        load_time(GRAN_MONTH, 2023, 1, 31, 0, 0, 0, 0, 1'b0);
        send_step(1'b1, 1'b0);
        send_step(1'b1, 1'b0);
        drain();
        load_time(GRAN_MONTH, 2023, 12, 15, 8, 0, 0, 0, 1'b0);
        send_step(1'b1, 1'b0);

        // Year unit: a leap day lands in a common year; the top year wraps.
        drain();
        load_time(GRAN_YEAR, 2024, 2, 29, 0, 0, 0, 0, 1'b0);
        send_step(1'b1, 1'b0);
        send_step(1'b1, 1'b0);
        drain();
        load_time(GRAN_YEAR, 4095, 6, 15, 0, 0, 0, 0, 1'b0);
        send_step(1'b1, 1'b0);

        // Month zero and day zero: the day is left alone until it grows past
        // 31, and month zero stays until a carry reaches it.
        drain();
        load_time(GRAN_DAY, 2023, 0, 0, 0, 0, 0, 0, 1'b0);
        send_step(1'b1, 1'b0);
        send_step(1'b0, 1'b0);
        drain();
        load_time(GRAN_DAY, 2023, 0, 31, 0, 0, 0, 0, 1'b0);
        send_step(1'b1, 1'b0);

        // Unused granularity: nothing is added, out-of-range fields are
        // still normalised by the carry chain.
        drain();
        load_time(GRAN_UNUSED, 2023, 2, 30, 30, 62, 62, 1010, 1'b0);
        send_step(1'b1, 1'b0);
        send_step(1'b1, 1'b0);

        // ---- Random part --------------------------------------------------

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain();
            unit = $urandom_range(0, 7);

            // Years divisible by 100 and years just below the wrap turn up
            // far more often than chance would give them.
            roll = $urandom_range(0, 99);
            if (roll < 20)
                start_year = $urandom_range(0, 40) * 100;
            else if (roll < 35)
                start_year = $urandom_range(4093, 4095);
            else
                start_year = $urandom_range(0, 4095);

            // Mostly reload the clock; otherwise change only the unit and
            // carry on from where the last phase stopped.
            if (phase == 0 || $urandom_range(0, 99) < 75) begin
                load_time(unit, start_year,
                          pick_field(1, 12, MONTH_W), pick_field(1, 31, DAY_W),
                          pick_field(0, 23, HOUR_W),  pick_field(0, 59, MIN_W),
                          pick_field(0, 59, SEC_W),   pick_field(0, 999, MSEC_W), 1'b1);
            end else begin
                write_field(REG_GRAN, unit, $bits(gran_t), 1'b1);
                cfg_valid <= 1'b0;
            end

            if (phase == 0) begin
                // Offer beats back to back into a stalled sink.
                hold_requests <= hold_requests + 1;
                burst = 1'b1;
                n     = 16;
            end else begin
                burst = ($urandom_range(0, 99) < 25);
                n     = $urandom_range(10, 60);
            end

            repeat (n) begin
                send_step(($urandom_range(0, 99) < 90), burst);
                random_sent++;
            end
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
